/* rtl/core/slwq_pkg.sv */
// Package: constants, codes and shared types of the line window query block.
`timescale 1ns / 1ps
package slwq_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_MATCHES = 64;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = IW + 1;
  localparam int SW = $clog2(MAX_MATCHES);
  localparam int NW = SW + 1;
  localparam int EW = 18;
  localparam int ZW = 7;
  localparam int KW = 3;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_WIN   = 3'd2;
  localparam logic [2:0] CMD_CTR   = 3'd3;
  localparam logic [2:0] CMD_AUTO  = 3'd4;

  // auto half-width a/50 + 50, tested as 50*|E-a| < a + 2500
  localparam int AUTO_MUL = 50;
  localparam int AUTO_OFS = 2500;

  typedef struct packed {
    logic [EW-1:0] energy;
    logic [ZW-1:0] elem;
    logic [KW-1:0] kind;
  } line_t;

  typedef struct packed {
    logic take;
    logic i_inc;
    logic grab;
    logic s_clr;
    logic s_inc;
    logic keep;
    logic set_trunc;
    logic emit_item;
    logic emit_empty;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic scan_done;
    logic hit;
    logic drop;
    logic cmp_last;
    logic n_zero;
    logic n_full;
    logic out_last;
  } ctl_stat_t;
endpackage

/* rtl/core/slwq_in_intf.sv */
// Interface: input channel of the line window query block.
`timescale 1ns / 1ps
interface slwq_in_intf;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [17:0] energy_a;
  logic [17:0] energy_b;
  logic [6:0]  atomic_number;
  logic [2:0]  line_kind;
  modport source (output valid, cmd, energy_a, energy_b, atomic_number, line_kind,
                  input ready);
  modport sink (input valid, cmd, energy_a, energy_b, atomic_number, line_kind,
                output ready);
endinterface

/* rtl/core/slwq_out_intf.sv */
// Interface: result channel of the line window query block.
`timescale 1ns / 1ps
interface slwq_out_intf;
  logic        valid;
  logic        ready;
  logic        found;
  logic [17:0] line_energy;
  logic [6:0]  line_element;
  logic [2:0]  line_type;
  logic        truncated;
  logic        table_full;
  logic        last;
  modport source (output valid, found, line_energy, line_element, line_type, truncated,
                  table_full, last, input ready);
  modport sink (input valid, found, line_energy, line_element, line_type, truncated,
                table_full, last, output ready);
endinterface

/* rtl/core/slwq_ctrl.sv */
// Controller: state machine sequencing scan, merge check and result beats.
`timescale 1ns / 1ps
module slwq_ctrl
  import slwq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd,
  output logic      in_ready,
  output logic      out_valid
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_KEEP  = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_WAIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = stat.is_query ? S_FETCH : S_WAIT;
        end
      end
      S_FETCH: begin
        if (!stat.scan_done) begin
          state_nxt = S_TEST;
        end else if (stat.n_zero) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_WAIT;
        end else begin
          cmd.s_clr = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_TEST: begin
        if (!stat.hit) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          cmd.grab  = 1'b1;
          cmd.s_clr = 1'b1;
          state_nxt = stat.n_zero ? S_KEEP : S_CMP;
        end
      end
      S_CMP: begin
        if (stat.drop) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_FETCH;
        end else if (stat.cmp_last) begin
          state_nxt = S_KEEP;
        end else begin
          cmd.s_inc = 1'b1;
        end
      end
      S_KEEP: begin
        if (stat.n_full) begin
          cmd.set_trunc = 1'b1;
          cmd.s_clr     = 1'b1;
          state_nxt     = S_LOAD;
        end else begin
          cmd.keep  = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_LOAD: begin
        cmd.emit_item = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          if (stat.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.s_inc = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* rtl/core/slwq_dp.sv */
// Datapath: line table, survivor list, window test, merge test, result register.
`timescale 1ns / 1ps
module slwq_dp
  import slwq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_cmd_t      cmd,
  output ctl_stat_t     stat,
  input  logic          cfg_we,
  input  logic [EW-1:0] cfg_wdata,
  input  logic [2:0]    in_cmd,
  input  logic [EW-1:0] in_energy_a,
  input  logic [EW-1:0] in_energy_b,
  input  logic [ZW-1:0] in_atomic_number,
  input  logic [KW-1:0] in_line_kind,
  output logic          out_found,
  output logic [EW-1:0] out_line_energy,
  output logic [ZW-1:0] out_line_element,
  output logic [KW-1:0] out_line_type,
  output logic          out_truncated,
  output logic          out_table_full,
  output logic          out_last
);
  line_t tbl_mem [TABLE_DEPTH];
  line_t surv_mem [MAX_MATCHES];
  line_t tbl_rd_r, surv_rd_r, cur_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [EW-1:0] min_sep_r;
  logic [2:0]    q_cmd_r;
  logic [EW-1:0] q_a_r, q_b_r;
  logic [CW-1:0] i_r, i_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic          trunc_r, trunc_nxt;

  logic          is_full, do_load;
  logic [EW-1:0] gap_q, gap_s;
  logic [23:0]   gap_x50, auto_lim;
  logic          hit;

  assign is_full = (count_r == CW'(TABLE_DEPTH));
  assign do_load = cmd.take && (in_cmd == CMD_LOAD) && !is_full;

  // window test on the entry read last cycle
  assign gap_q    = (tbl_rd_r.energy > q_a_r) ? tbl_rd_r.energy - q_a_r
                                              : q_a_r - tbl_rd_r.energy;
  assign gap_x50  = 24'(gap_q) * 24'(AUTO_MUL);
  assign auto_lim = 24'(q_a_r) + 24'(AUTO_OFS);

  always_comb begin
    case (q_cmd_r)
      CMD_WIN: hit = (tbl_rd_r.energy > q_a_r) && (tbl_rd_r.energy < q_b_r);
      CMD_CTR: hit = gap_q < q_b_r;
      default: hit = gap_x50 < auto_lim;
    endcase
  end

  assign gap_s = (cur_r.energy > surv_rd_r.energy) ? cur_r.energy - surv_rd_r.energy
                                                   : surv_rd_r.energy - cur_r.energy;

  always_comb begin
    stat.is_query  = (in_cmd == CMD_WIN) || (in_cmd == CMD_CTR) || (in_cmd == CMD_AUTO);
    stat.scan_done = (i_r == count_r);
    stat.hit       = hit;
    stat.drop      = (surv_rd_r.elem == cur_r.elem) && (gap_s < min_sep_r);
    stat.cmp_last  = ({1'b0, s_r} + NW'(1)) == n_r;
    stat.n_zero    = (n_r == '0);
    stat.n_full    = (n_r == NW'(MAX_MATCHES));
    stat.out_last  = out_last;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.take && in_cmd == CMD_CLEAR) count_nxt = '0;
    else if (do_load)                    count_nxt = count_r + CW'(1);
    i_nxt = i_r;
    if (cmd.take)                  i_nxt = '0;
    else if (cmd.i_inc || cmd.keep) i_nxt = i_r + CW'(1);
    n_nxt = n_r;
    if (cmd.take)      n_nxt = '0;
    else if (cmd.keep) n_nxt = n_r + NW'(1);
    s_nxt = s_r;
    if (cmd.s_clr)      s_nxt = '0;
    else if (cmd.s_inc) s_nxt = s_r + SW'(1);
    trunc_nxt = trunc_r;
    if (cmd.take)           trunc_nxt = 1'b0;
    else if (cmd.set_trunc) trunc_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      min_sep_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) min_sep_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    trunc_r <= trunc_nxt;
    if (cmd.take) begin
      q_cmd_r <= in_cmd;
      q_a_r   <= in_energy_a;
      q_b_r   <= in_energy_b;
    end
    if (cmd.grab) cur_r <= tbl_rd_r;
  end

  // table and survivor list, registered reads
  always_ff @(posedge clk) begin
    if (do_load) tbl_mem[count_r[IW-1:0]] <= '{in_energy_a, in_atomic_number, in_line_kind};
    tbl_rd_r <= tbl_mem[i_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.keep) surv_mem[n_r[SW-1:0]] <= cur_r;
    surv_rd_r <= surv_mem[s_nxt];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.take || cmd.emit_empty) begin
      out_found        <= 1'b0;
      out_line_energy  <= '0;
      out_line_element <= '0;
      out_line_type    <= '0;
      out_truncated    <= 1'b0;
      out_table_full   <= cmd.take && (in_cmd == CMD_LOAD) && is_full;
      out_last         <= 1'b1;
    end else if (cmd.emit_item) begin
      out_found        <= 1'b1;
      out_line_energy  <= surv_rd_r.energy;
      out_line_element <= surv_rd_r.elem;
      out_line_type    <= surv_rd_r.kind;
      out_truncated    <= stat.cmp_last && trunc_r;
      out_table_full   <= 1'b0;
      out_last         <= stat.cmp_last;
    end
  end
endmodule

/* rtl/core/sorted_line_window_query_top.sv */
// Top level: emission-line table with energy window queries and merging.
`timescale 1ns / 1ps
// Holds up to TABLE_DEPTH lines (energy, element, kind) loaded in order;
// cmd 0 clears, cmd 1 loads, cmds 2..4 query a window (open interval,
// centre +/- half-width, centre with auto half-width a/50+50 eV). One beat
// in at a time: in_bus.ready is high only while the block is idle. Clear,
// load and unknown commands present their one beat in the cycle after the
// input beat is taken. A query walks the stored entries in table order
// through one registered table port (S_FETCH, then S_TEST), stopping early
// only when an entry that passes the merge check finds the survivor list
// full; an entry inside the window goes through the merge check (S_CMP)
// against the lines kept so far, stepping through the survivor list one
// entry a cycle (a dropped entry leaves the check early), and a kept entry
// is then stored (S_KEEP). Kept lines are then sent one beat each, loaded
// (S_LOAD) and held (S_WAIT) until the sink takes it. A line is dropped if
// it lies closer than min_separation (cfg_wdata) to an already kept line of
// the same element; at most MAX_MATCHES lines are sent, with truncated set
// on the final beat when more existed. An empty answer is a single beat with found low. No clearing pass after reset.
module sorted_line_window_query_top
  import slwq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  slwq_in_intf.sink     in_bus,
  slwq_out_intf.source  out_bus,
  input  logic          cfg_we,
  input  logic [EW-1:0] cfg_wdata
);
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  slwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid)
  );

  slwq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_bus.cmd),
    .in_energy_a      (in_bus.energy_a),
    .in_energy_b      (in_bus.energy_b),
    .in_atomic_number (in_bus.atomic_number),
    .in_line_kind     (in_bus.line_kind),
    .out_found        (out_bus.found),
    .out_line_energy  (out_bus.line_energy),
    .out_line_element (out_bus.line_element),
    .out_line_type    (out_bus.line_type),
    .out_truncated    (out_bus.truncated),
    .out_table_full   (out_bus.table_full),
    .out_last         (out_bus.last)
  );
endmodule

/* rtl/core/slwq_checker.sv */
// Checker: port-level properties of the line window query block, with bind.
`timescale 1ns / 1ps
module slwq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [17:0] line_energy,
  input logic        truncated,
  input logic        last
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted beat while busy");
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("result beat while idle");
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> last) else $error("not-found beat not last");
  a_trunc_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && truncated |-> last && found) else $error("truncated misplaced");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_energy) && $stable(last))
    else $error("stalled beat changed");
endmodule

bind sorted_line_window_query_top slwq_checker u_slwq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .found       (out_bus.found),
  .line_energy (out_bus.line_energy),
  .truncated   (out_bus.truncated),
  .last        (out_bus.last)
);
